// File: src/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg: shared types and constants of the channel threshold monitor
// Widths, status codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package ctm_pkg;

  localparam int CHANNELS  = 16;
  localparam int CH_W      = 4;
  localparam int VAL_W     = 32;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] STALE_TIMEOUT_RST = 32'd5000;

  // channel status codes
  localparam logic [STATUS_W-1:0] ST_NORMAL  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WARNING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ALARM   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_STALE   = 2'd3;

  // request kinds
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;

  // bound_enables bit positions
  localparam int EN_WARN_LOW   = 0;
  localparam int EN_WARN_HIGH  = 1;
  localparam int EN_ALARM_LOW  = 2;
  localparam int EN_ALARM_HIGH = 3;

  typedef struct packed {
    logic signed [VAL_W-1:0] warn_low;
    logic signed [VAL_W-1:0] warn_high;
    logic signed [VAL_W-1:0] alarm_low;
    logic signed [VAL_W-1:0] alarm_high;
    logic [3:0]              bound_enables;
    logic [TIME_W-1:0]       stale_timeout_ms;
  } cfg_t;

endpackage

// File: src/ctm_in_if.sv
// ----------------------------------------------------------------------------
// ctm_in_if: request channel of the monitor
// Valid/ready channel carrying one sample or check request.
// ----------------------------------------------------------------------------
interface ctm_in_if
  import ctm_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [CH_W-1:0]         channel;
  logic signed [VAL_W-1:0] sample_value;
  logic [TIME_W-1:0]       now_ms;

  modport source (output valid, action, channel, sample_value, now_ms, input ready);
  modport sink   (input valid, action, channel, sample_value, now_ms, output ready);
endinterface

// File: src/ctm_out_if.sv
// ----------------------------------------------------------------------------
// ctm_out_if: result channel of the monitor
// Valid/ready channel carrying channel status and running min/max.
// ----------------------------------------------------------------------------
interface ctm_out_if
  import ctm_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         out_channel;
  logic [STATUS_W-1:0]     channel_status;
  logic signed [VAL_W-1:0] running_min;
  logic signed [VAL_W-1:0] running_max;
  logic                    min_max_valid;

  modport source (output valid, out_channel, channel_status, running_min, running_max,
                  min_max_valid, input ready);
  modport sink   (input valid, out_channel, channel_status, running_min, running_max,
                  min_max_valid, output ready);
endinterface

// File: src/ctm_cfg_if.sv
// ----------------------------------------------------------------------------
// ctm_cfg_if: register write channel of the monitor
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ctm_cfg_if
  import ctm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/channel_threshold_monitor.sv
// ----------------------------------------------------------------------------
// channel_threshold_monitor: per-channel min/max and threshold monitor
// Tracks running extremes, bound status and staleness of 16 channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  - sample (action 0) or staleness check (action 1) of a channel.
//   out_item - one result per request: channel, status, running min/max and
//              a flag telling whether the channel has had a sample yet.
//   cfg_wr   - register writes (bounds, enables, stale timeout); always
//              ready. Write only while no request is in flight.
// A request register feeds a single read-modify-write of the channel entry,
// which loads the result register that drives out_item. One request per
// cycle is sustained while out_item.ready stays high. Same-channel requests
// back to back see each other's updates.
// Reset clears the request and result valids, the seen flags and all
// statuses (normal); registers return to zero bounds, all bounds disabled,
// and a 5000 ms timeout. If the receiver stalls, the result register holds
// and one more request is taken into the request register, after which
// in_item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module channel_threshold_monitor
  import ctm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ctm_in_if.sink    in_item,
  ctm_out_if.source out_item,
  ctm_cfg_if.sink   cfg_wr
);

  cfg_t cfg;

  ctm_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  ctm_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // nothing comes out in the cycle right after reset
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_item.valid)
    else $error("result valid right after reset");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && !out_item.min_max_valid) |->
      (out_item.running_min == '0 && out_item.running_max == '0))
    else $error("unseen channel reports nonzero extremes");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.min_max_valid) |->
      (out_item.running_min <= out_item.running_max))
    else $error("running min above running max");

  a_stale_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.channel_status == ST_STALE) |-> out_item.min_max_valid)
    else $error("stale status on a channel never sampled");

endmodule

// File: src/ctm_cfg_regs.sv
// ----------------------------------------------------------------------------
// ctm_cfg_regs: threshold and timeout registers
// Decodes register writes; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ctm_cfg_regs
  import ctm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ctm_cfg_if.sink   cfg_wr,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_wr.ready = 1'b1;
  assign wr_en        = cfg_wr.valid;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_wr.index)
        REG_WARN_LOW:   cfg_nxt.warn_low         = cfg_wr.data;
        REG_WARN_HIGH:  cfg_nxt.warn_high        = cfg_wr.data;
        REG_ALARM_LOW:  cfg_nxt.alarm_low        = cfg_wr.data;
        REG_ALARM_HIGH: cfg_nxt.alarm_high       = cfg_wr.data;
        REG_ENABLES:    cfg_nxt.bound_enables    = cfg_wr.data[3:0];
        REG_TIMEOUT:    cfg_nxt.stale_timeout_ms = cfg_wr.data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warn_low         <= '0;
      cfg_r.warn_high        <= '0;
      cfg_r.alarm_low        <= '0;
      cfg_r.alarm_high       <= '0;
      cfg_r.bound_enables    <= '0;
      cfg_r.stale_timeout_ms <= STALE_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/ctm_classify.sv
// ----------------------------------------------------------------------------
// ctm_classify: bound check of one sample
// Priority: alarm low, alarm high, warn low, warn high, else normal.
// ----------------------------------------------------------------------------
module ctm_classify
  import ctm_pkg::*;
(
  input  logic signed [VAL_W-1:0] value,
  input  cfg_t                    cfg,
  output logic [STATUS_W-1:0]     status
);

  logic below_al;
  logic above_ah;
  logic below_wl;
  logic above_wh;

  assign below_al = cfg.bound_enables[EN_ALARM_LOW]  && (value < cfg.alarm_low);
  assign above_ah = cfg.bound_enables[EN_ALARM_HIGH] && (value > cfg.alarm_high);
  assign below_wl = cfg.bound_enables[EN_WARN_LOW]   && (value < cfg.warn_low);
  assign above_wh = cfg.bound_enables[EN_WARN_HIGH]  && (value > cfg.warn_high);

  always_comb begin
    priority if (below_al || above_ah) begin
      status = ST_ALARM;
    end else if (below_wl || above_wh) begin
      status = ST_WARNING;
    end else begin
      status = ST_NORMAL;
    end
  end

endmodule

// File: src/ctm_core.sv
// ----------------------------------------------------------------------------
// ctm_core: request register, per-channel state and result register
// One read-modify-write of a channel entry per cycle while the result register can advance.
// ----------------------------------------------------------------------------
module ctm_core
  import ctm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  ctm_in_if.sink    in_item,
  ctm_out_if.source out_item
);

  // request register
  logic                    req_v_r;
  logic                    req_act_r;
  logic [CH_W-1:0]         req_ch_r;
  logic signed [VAL_W-1:0] req_val_r;
  logic [TIME_W-1:0]       req_now_r;

  // channel state
  logic signed [VAL_W-1:0] min_r    [CHANNELS];
  logic signed [VAL_W-1:0] max_r    [CHANNELS];
  logic [TIME_W-1:0]       last_r   [CHANNELS];
  logic [CHANNELS-1:0]     seen_r;
  logic [STATUS_W-1:0]     status_r [CHANNELS];

  // result register
  logic                    res_v_r;
  logic [CH_W-1:0]         res_ch_r;
  logic [STATUS_W-1:0]     res_status_r;
  logic signed [VAL_W-1:0] res_min_r;
  logic signed [VAL_W-1:0] res_max_r;
  logic                    res_mmv_r;

  logic                    advance;
  logic                    fire;
  logic                    take;
  logic                    ch_ok;
  logic                    seen;
  logic signed [VAL_W-1:0] cur_min;
  logic signed [VAL_W-1:0] cur_max;
  logic [TIME_W-1:0]       elapsed;
  logic [STATUS_W-1:0]     cls_status;
  logic signed [VAL_W-1:0] min_nxt;
  logic signed [VAL_W-1:0] max_nxt;
  logic [STATUS_W-1:0]     status_nxt;
  logic                    seen_nxt;
  logic                    is_sample;

  assign advance       = !res_v_r || out_item.ready;
  assign fire          = req_v_r && advance;
  assign in_item.ready = !req_v_r || advance;
  assign take          = in_item.valid && in_item.ready;

  assign ch_ok     = ({24'd0, req_ch_r} < 28'(CHANNELS));
  assign seen      = seen_r[req_ch_r];
  assign cur_min   = min_r[req_ch_r];
  assign cur_max   = max_r[req_ch_r];
  assign elapsed   = req_now_r - last_r[req_ch_r];
  assign is_sample = (req_act_r == ACT_SAMPLE);

  ctm_classify u_classify (
    .value  (req_val_r),
    .cfg    (cfg),
    .status (cls_status)
  );

  always_comb begin
    min_nxt    = cur_min;
    max_nxt    = cur_max;
    seen_nxt   = seen;
    status_nxt = status_r[req_ch_r];
    if (is_sample) begin
      if (!seen || req_val_r < cur_min) min_nxt = req_val_r;
      if (!seen || req_val_r > cur_max) max_nxt = req_val_r;
      seen_nxt   = 1'b1;
      status_nxt = cls_status;
    end else if (seen && (elapsed > cfg.stale_timeout_ms)) begin
      status_nxt = ST_STALE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_item.ready) begin
      req_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_act_r <= in_item.action;
      req_ch_r  <= in_item.channel;
      req_val_r <= in_item.sample_value;
      req_now_r <= in_item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      for (int i = 0; i < CHANNELS; i++) status_r[i] <= ST_NORMAL;
    end else if (fire && ch_ok) begin
      seen_r[req_ch_r]   <= seen_nxt;
      status_r[req_ch_r] <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ch_ok && is_sample) begin
      min_r[req_ch_r]  <= min_nxt;
      max_r[req_ch_r]  <= max_nxt;
      last_r[req_ch_r] <= req_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (advance) begin
      res_v_r <= req_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_ch_r     <= req_ch_r;
      res_status_r <= ch_ok ? status_nxt : ST_NORMAL;
      res_min_r    <= (ch_ok && seen_nxt) ? min_nxt : '0;
      res_max_r    <= (ch_ok && seen_nxt) ? max_nxt : '0;
      res_mmv_r    <= ch_ok && seen_nxt;
    end
  end

  assign out_item.valid          = res_v_r;
  assign out_item.out_channel    = res_ch_r;
  assign out_item.channel_status = res_status_r;
  assign out_item.running_min    = res_min_r;
  assign out_item.running_max    = res_max_r;
  assign out_item.min_max_valid  = res_mmv_r;

endmodule

// File: tb/ctm_checker.sv
// ----------------------------------------------------------------------------
// ctm_checker: result checker of the channel threshold monitor
// Watches the request, result and register channels, keeps its own copy of
// every channel entry and of the thresholds, and compares each result with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ctm_checker
  import ctm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ctm_in_if    req_mon,
  ctm_out_if   res_mon,
  ctm_cfg_if   cfg_mon,
  output int   fail_count,
  output int   results_due,
  output int   n_results,
  output int   n_warning,
  output int   n_alarm,
  output int   n_stale
);

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic                    seen;
  } channel_report_t;

  cfg_t                    limits;
  logic signed [VAL_W-1:0] lo_store    [CHANNELS];
  logic signed [VAL_W-1:0] hi_store    [CHANNELS];
  logic [TIME_W-1:0]       stamp_store [CHANNELS];
  logic                    seen_store  [CHANNELS];
  logic [STATUS_W-1:0]     state_store [CHANNELS];
  channel_report_t         outstanding [$];

  // strict compares, alarms win over warnings
  function automatic logic [STATUS_W-1:0] grade_value(input logic signed [VAL_W-1:0] v);
    if (limits.bound_enables[EN_ALARM_LOW] && v < $signed(limits.alarm_low))
      return ST_ALARM;
    if (limits.bound_enables[EN_ALARM_HIGH] && v > $signed(limits.alarm_high))
      return ST_ALARM;
    if (limits.bound_enables[EN_WARN_LOW] && v < $signed(limits.warn_low))
      return ST_WARNING;
    if (limits.bound_enables[EN_WARN_HIGH] && v > $signed(limits.warn_high))
      return ST_WARNING;
    return ST_NORMAL;
  endfunction

  function automatic channel_report_t advance_channel(input logic act,
                                                      input logic [CH_W-1:0] ch,
                                                      input logic signed [VAL_W-1:0] v,
                                                      input logic [TIME_W-1:0] now);
    channel_report_t r;
    logic [TIME_W-1:0] elapsed;
    if (act == ACT_SAMPLE) begin
      if (!seen_store[ch] || v < lo_store[ch]) lo_store[ch] = v;
      if (!seen_store[ch] || v > hi_store[ch]) hi_store[ch] = v;
      seen_store[ch]  = 1'b1;
      stamp_store[ch] = now;
      state_store[ch] = grade_value(v);
    end else begin
      elapsed = now - stamp_store[ch];  // wraps modulo 2^32
      if (seen_store[ch] && elapsed > limits.stale_timeout_ms) state_store[ch] = ST_STALE;
    end
    r.ch     = ch;
    r.status = state_store[ch];
    r.seen   = seen_store[ch];
    r.lo     = seen_store[ch] ? lo_store[ch] : '0;
    r.hi     = seen_store[ch] ? hi_store[ch] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    channel_report_t got;
    channel_report_t want;
    if (!rst_n) begin
      limits.warn_low         = '0;
      limits.warn_high        = '0;
      limits.alarm_low        = '0;
      limits.alarm_high       = '0;
      limits.bound_enables    = '0;
      limits.stale_timeout_ms = STALE_TIMEOUT_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        seen_store[c]  = 1'b0;
        state_store[c] = ST_NORMAL;
        lo_store[c]    = '0;
        hi_store[c]    = '0;
        stamp_store[c] = '0;
      end
      outstanding.delete();
      fail_count = 0;
      n_results  = 0;
      n_warning  = 0;
      n_alarm    = 0;
      n_stale    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_WARN_LOW:   limits.warn_low         = cfg_mon.data;
          REG_WARN_HIGH:  limits.warn_high        = cfg_mon.data;
          REG_ALARM_LOW:  limits.alarm_low        = cfg_mon.data;
          REG_ALARM_HIGH: limits.alarm_high       = cfg_mon.data;
          REG_ENABLES:    limits.bound_enables    = cfg_mon.data[3:0];
          REG_TIMEOUT:    limits.stale_timeout_ms = cfg_mon.data;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        outstanding.push_back(advance_channel(req_mon.action, req_mon.channel,
                                              req_mon.sample_value, req_mon.now_ms));
      if (res_mon.valid && res_mon.ready) begin
        got.ch     = res_mon.out_channel;
        got.status = res_mon.channel_status;
        got.lo     = res_mon.running_min;
        got.hi     = res_mon.running_max;
        got.seen   = res_mon.min_max_valid;
        n_results++;
        case (got.status)
          ST_WARNING: n_warning++;
          ST_ALARM:   n_alarm++;
          ST_STALE:   n_stale++;
          default: ;
        endcase
        if (outstanding.size() == 0) begin
          $display("%0t: unexpected result ch=%0d st=%0d min=%0d max=%0d seen=%0b",
                   $time, got.ch, got.status, got.lo, got.hi, got.seen);
          fail_count++;
        end else begin
          want = outstanding.pop_front();
          if (got.ch != want.ch || got.status != want.status || got.lo != want.lo ||
              got.hi != want.hi || got.seen != want.seen) begin
            $display("%0t: mismatch expected ch=%0d st=%0d min=%0d max=%0d seen=%0b",
                     $time, want.ch, want.status, want.lo, want.hi, want.seen);
            $display("%0t:          actual   ch=%0d st=%0d min=%0d max=%0d seen=%0b",
                     $time, got.ch, got.status, got.lo, got.hi, got.seen);
            fail_count++;
          end
        end
      end
    end
    results_due = outstanding.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top of the channel threshold monitor verification
// Drives directed and random sample/check requests under several threshold
// settings with random stalls on both channels; the checker does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ctm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 190;

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {SET_ORDERED, SET_OPEN, SET_TIGHT, SET_WILD} setting_style_e;

  logic clk;
  logic rst_n;
  bit   steady;
  int   fail_count, results_due, n_results, n_warning, n_alarm, n_stale;
  int   n_samples, n_checks, n_settings;
  cfg_t active;

  ctm_in_if  req();
  ctm_out_if res();
  ctm_cfg_if cfg();

  channel_threshold_monitor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (req),
    .out_item (res),
    .cfg_wr   (cfg)
  );

  ctm_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req),
    .res_mon     (res),
    .cfg_mon     (cfg),
    .fail_count  (fail_count),
    .results_due (results_due),
    .n_results   (n_results),
    .n_warning   (n_warning),
    .n_alarm     (n_alarm),
    .n_stale     (n_stale)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result sink: bursts of ready and stalls, mostly short
  initial begin
    int hold;
    bit on;
    hold = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (steady) begin
        res.ready <= 1'b1;
      end else if (hold == 0) begin
        on = ($urandom_range(0, 3) != 0);
        if (on) hold = $urandom_range(1, 12);
        else if ($urandom_range(0, 9) == 0) hold = $urandom_range(8, 40);
        else hold = $urandom_range(1, 3);
        res.ready <= on;
      end else begin
        hold--;
      end
    end
  end

  // no handshake anywhere for too long ends the run
  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[channel_threshold_monitor] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    bit hit;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    do begin
      @(negedge clk);
      hit = cfg.ready;
      @(posedge clk);
    end while (!hit);
  endtask

  task automatic write_settings(input cfg_t s);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_WARN_LOW, s.warn_low);
    write_reg(REG_WARN_HIGH, s.warn_high);
    write_reg(REG_ALARM_LOW, s.alarm_low);
    write_reg(REG_ALARM_HIGH, s.alarm_high);
    // upper bits of the enables write are junk on purpose
    write_reg(REG_ENABLES, {28'($urandom), s.bound_enables});
    write_reg(REG_TIMEOUT, s.stale_timeout_ms);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE_B, $urandom);
    cfg.valid <= 1'b0;
    active = s;
    n_settings++;
  endtask

  task automatic push_req(input logic act, input logic [CH_W-1:0] ch,
                          input logic signed [VAL_W-1:0] v, input logic [TIME_W-1:0] now);
    int gap;
    bit hit;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.channel      <= ch;
    req.sample_value <= v;
    req.now_ms       <= now;
    do begin
      @(negedge clk);
      hit = req.ready;
      @(posedge clk);
    end while (!hit);
    if (act == ACT_SAMPLE) n_samples++;
    else n_checks++;
  endtask

  // stop requesting and wait until every request has come back
  task automatic drain_results();
    req.valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic cfg_t make_settings(input setting_style_e style);
    cfg_t s;
    logic signed [VAL_W-1:0] mid, w, a;
    case (style)
      SET_ORDERED: begin
        mid = 32'($urandom_range(0, 13107200)) - 32'd6553600;   // +-100.0
        w   = 32'($urandom_range(1, 32'h0032_0000));
        a   = 32'($urandom_range(1, 32'h0032_0000));
        s.warn_low         = mid - w;
        s.warn_high        = mid + w;
        s.alarm_low        = mid - w - a;
        s.alarm_high       = mid + w + a;
        s.bound_enables    = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
        s.stale_timeout_ms = $urandom_range(20, 400);
      end
      SET_OPEN: begin
        s.warn_low         = 32'h8000_0000;
        s.warn_high        = 32'h7FFF_FFFF;
        s.alarm_low        = 32'h8000_0000;
        s.alarm_high       = 32'h7FFF_FFFF;
        s.bound_enables    = 4'hF;
        s.stale_timeout_ms = '0;
      end
      SET_TIGHT: begin
        s.warn_low         = '0;
        s.warn_high        = '0;
        s.alarm_low        = '0;
        s.alarm_high       = '0;
        s.bound_enables    = 4'hF;
        s.stale_timeout_ms = 32'hFFFF_FFFF;
      end
      default: begin
        s.warn_low         = $urandom;
        s.warn_high        = $urandom;
        s.alarm_low        = $urandom;
        s.alarm_high       = $urandom;
        s.bound_enables    = 4'($urandom_range(0, 15));
        s.stale_timeout_ms = $urandom >> $urandom_range(0, 31);
      end
    endcase
    return s;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 3))
          0: b = active.warn_low;
          1: b = active.warn_high;
          2: b = active.alarm_low;
          default: b = active.alarm_high;
        endcase
        return b + 32'($urandom_range(0, 2)) - 32'd1;
      end
      4, 5, 6: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    setting_style_e plan [6];
    cfg_t d;
    logic [TIME_W-1:0] clock_ms, now, hint;
    logic [CH_W-1:0] hot, ch;
    logic act;

    plan = '{SET_ORDERED, SET_OPEN, SET_ORDERED, SET_WILD, SET_TIGHT, SET_ORDERED};
    n_samples  = 0;
    n_checks   = 0;
    n_settings = 0;
    steady     = 1'b0;
    rst_n      = 1'b0;
    req.valid        = 1'b0;
    req.action       = ACT_SAMPLE;
    req.channel      = '0;
    req.sample_value = '0;
    req.now_ms       = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_WARN_LOW;
    cfg.data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warn at +-10.0, alarm at +-20.0, 1 s timeout
    d = '{warn_low: 32'hFFF6_0000, warn_high: 32'h000A_0000, alarm_low: 32'hFFEC_0000,
          alarm_high: 32'h0014_0000, bound_enables: 4'hF, stale_timeout_ms: 32'd1000};
    write_settings(d);
    push_req(ACT_CHECK,  4'd3,  '0,            32'd0);        // never sampled
    push_req(ACT_SAMPLE, 4'd0,  '0,            32'd100);
    push_req(ACT_SAMPLE, 4'd0,  32'h8000_0000, 32'd110);
    push_req(ACT_SAMPLE, 4'd0,  32'h7FFF_FFFF, 32'd120);
    push_req(ACT_SAMPLE, 4'd1,  32'hFFF1_0000, 32'd200);
    push_req(ACT_SAMPLE, 4'd1,  32'h000F_0000, 32'd210);
    push_req(ACT_SAMPLE, 4'd1,  32'hFFEC_0000, 32'd220);      // on the alarm bound
    push_req(ACT_SAMPLE, 4'd1,  32'h0014_0000, 32'd230);
    push_req(ACT_SAMPLE, 4'd1,  32'h000A_0000, 32'd240);      // on the warn bound
    push_req(ACT_CHECK,  4'd1,  '0,            32'd1240);     // exactly the timeout
    push_req(ACT_CHECK,  4'd1,  '0,            32'd1241);
    push_req(ACT_CHECK,  4'd1,  '0,            32'd1300);     // stale sticks
    push_req(ACT_SAMPLE, 4'd1,  32'hFFF6_0000, 32'd1400);     // sample clears stale
    push_req(ACT_SAMPLE, 4'd15, 32'h0001_0000, 32'hFFFF_FF00);
    push_req(ACT_CHECK,  4'd15, '0,            32'h0000_0100); // wrapped, still fresh
    push_req(ACT_CHECK,  4'd15, '0,            32'h0000_02E9); // wrapped, stale
    push_req(ACT_CHECK,  4'd7,  '0,            32'hFFFF_FFFF);
    drain_results();

    // all bounds off, zero timeout
    d.bound_enables    = 4'h0;
    d.stale_timeout_ms = '0;
    write_settings(d);
    push_req(ACT_SAMPLE, 4'd0, 32'h8000_0000, 32'd500);
    push_req(ACT_SAMPLE, 4'd2, 32'hFFFF_FFFF, 32'd500);
    push_req(ACT_CHECK,  4'd2, '0,            32'd500);
    push_req(ACT_CHECK,  4'd2, '0,            32'd501);
    drain_results();

    // low bounds only, longest timeout
    d.bound_enables    = 4'b0101;
    d.stale_timeout_ms = 32'hFFFF_FFFF;
    write_settings(d);
    push_req(ACT_SAMPLE, 4'd4, 32'h7FFF_FFFF, 32'd600);
    push_req(ACT_SAMPLE, 4'd4, 32'hFFE7_0000, 32'd600);
    push_req(ACT_CHECK,  4'd4, '0,            32'd599);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      write_settings(make_settings(plan[p]));
      steady   = (p == 0 || p == 3);
      clock_ms = (p == 4) ? 32'hFFFF_F000 : $urandom;
      hot      = 4'($urandom_range(0, 15));
      if (active.stale_timeout_ms == 0) hint = 16;
      else if (active.stale_timeout_ms > 2000) hint = 2000;
      else hint = active.stale_timeout_ms;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) clock_ms += $urandom_range(0, 3 * hint);
        else clock_ms += $urandom_range(0, hint / 8 + 1);
        now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        ch  = ($urandom_range(0, 1) == 0) ? hot + 4'($urandom_range(0, 2))
                                          : 4'($urandom_range(0, 15));
        act = ($urandom_range(0, 99) < 55) ? ACT_SAMPLE : ACT_CHECK;
        push_req(act, ch, pick_value(), now);
      end
      drain_results();
    end

    steady = 1'b0;
    repeat (8) @(posedge clk);
    $display("%0d requests (%0d samples, %0d checks) under %0d threshold settings",
             n_samples + n_checks, n_samples, n_checks, n_settings);
    $display("%0d results checked: %0d warning, %0d alarm, %0d stale",
             n_results, n_warning, n_alarm, n_stale);
    if (fail_count == 0 && results_due == 0)
      $display("[channel_threshold_monitor] OK");
    else
      $display("[channel_threshold_monitor] ERROR");
    $finish;
  end

endmodule
